// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mfpe_pkg.sv -----
// Package for the monochrome framebuffer pixel engine: geometry constants,
// operation codes, payload structs and controller/datapath command types. No dependencies.
`timescale 1ns / 1ps

package mfpe_pkg;

    // Display geometry
    localparam int SCREEN_BYTES  = 9600;
    localparam int BYTES_PER_ROW = 40;
    localparam int MEM_DEPTH     = 32768;
    localparam int CLEAR_BYTES   = 2 * SCREEN_BYTES;

    localparam int ADDR_W  = $clog2(MEM_DEPTH);
    localparam int COORD_W = 9;

    localparam logic [COORD_W-1:0] WIDTH_PX  = COORD_W'(BYTES_PER_ROW * 8);
    localparam logic [COORD_W-1:0] HEIGHT_PX = COORD_W'(SCREEN_BYTES / BYTES_PER_ROW);

    // Only this select value moves drawing into the second screen
    localparam logic [1:0] SCREEN_TWO = 2'd2;

    // Configuration register indexes
    localparam logic REG_SCREEN_SELECT = 1'b0;
    localparam logic REG_PORTRAIT_MODE = 1'b1;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_FILL  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               pixel_on;
    } request_t;

    typedef struct packed {
        logic pixel_value;
        logic status;
    } result_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // latch a new request
        logic reject;      // flag the request as out of range
        logic mem_read;    // read the byte under the pixel cursor
        logic mem_write;   // write back the modified byte
        logic capture;     // sample the pixel bit for get pixel
        logic pix_step;    // advance the rectangle cursor
        logic clr_init;    // rewind the clear counter
        logic clr_write;   // zero one byte and advance the clear counter
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        op_t  op;
        logic range_ok;
        logic rect_empty;
        logic last_pixel;
        logic last_clear;
    } dp_stat_t;

endpackage

// ----- rtl/mfpe_datapath.sv -----
// Datapath of the pixel engine: request registers, pixel cursor, address and mask
// generation, clear counter and the display memory. Depends on mfpe_pkg.
`timescale 1ns / 1ps

module mfpe_datapath
    import mfpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  request_t   request,
    input  logic [1:0] screen_select,
    input  logic       portrait_mode,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output result_t    result
);

    op_t                op_reg;
    logic [COORD_W-1:0] x0_reg;
    logic [COORD_W-1:0] x1_reg;
    logic [COORD_W-1:0] y1_reg;
    logic               on_reg;
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_y_reg;
    logic               value_reg;
    logic               status_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [7:0]         rdata_reg;

    logic [7:0] mem [MEM_DEPTH];

    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  row_off;
    logic [ADDR_W-1:0]  pix_addr;
    logic [7:0]         mask;
    logic [7:0]         pix_wdata;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;
    logic               mem_we;
    logic [COORD_W-1:0] area_w;
    logic [COORD_W-1:0] area_h;
    logic               pix_ok;
    logic               fill_ok;
    logic [COORD_W:0]   x_inc;
    logic [COORD_W:0]   y_inc;
    logic               row_end;

    // Pixel to byte address and bit mask; portrait rows run from the right edge
    always_comb
    begin
        pix_col  = portrait_mode ? cur_y_reg : cur_x_reg;
        pix_row  = portrait_mode ? (HEIGHT_PX - COORD_W'(1) - cur_x_reg) : cur_y_reg;
        base     = (screen_select == SCREEN_TWO) ? ADDR_W'(SCREEN_BYTES) : '0;
        row_off  = ADDR_W'(pix_row) * ADDR_W'(BYTES_PER_ROW);
        pix_addr = base + ADDR_W'(pix_col >> 3) + row_off;
        mask     = 8'h80 >> pix_col[2:0];
        pix_wdata = on_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
    end

    // Range checks for the active orientation
    always_comb
    begin
        area_w  = portrait_mode ? HEIGHT_PX : WIDTH_PX;
        area_h  = portrait_mode ? WIDTH_PX : HEIGHT_PX;
        pix_ok  = (cur_x_reg < area_w) && (cur_y_reg < area_h);
        fill_ok = (cur_x_reg <= area_w) && (x1_reg <= area_w)
                  && (cur_y_reg <= area_h) && (y1_reg <= area_h);
    end

    // Rectangle cursor end detection
    always_comb
    begin
        x_inc   = {1'b0, cur_x_reg} + (COORD_W + 1)'(1);
        y_inc   = {1'b0, cur_y_reg} + (COORD_W + 1)'(1);
        row_end = (x_inc == {1'b0, x1_reg});
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.range_ok   = (op_reg == OP_FILL) ? fill_ok : pix_ok;
        stat.rect_empty = (cur_x_reg >= x1_reg) || (cur_y_reg >= y1_reg);
        stat.last_pixel = row_end && (y_inc == {1'b0, y1_reg});
        stat.last_clear = (clr_cnt_reg == ADDR_W'(CLEAR_BYTES - 1));
    end

    // Request registers and pixel cursor
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= request.operation;
            x0_reg     <= request.x_start;
            x1_reg     <= request.x_end;
            y1_reg     <= request.y_end;
            on_reg     <= request.pixel_on;
            cur_x_reg  <= request.x_start;
            cur_y_reg  <= request.y_start;
            value_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.reject)
            begin
                status_reg <= 1'b1;
            end
            if (cmd.capture)
            begin
                value_reg <= |(rdata_reg & mask);
            end
            if (cmd.pix_step)
            begin
                if (row_end)
                begin
                    cur_x_reg <= x0_reg;
                    cur_y_reg <= y_inc[COORD_W-1:0];
                end
                else
                begin
                    cur_x_reg <= x_inc[COORD_W-1:0];
                end
            end
        end
    end

    // Clear counter; starts at zero so the post-reset sweep begins at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_init)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    // Single-port display memory with registered read
    always_comb
    begin
        mem_we    = cmd.mem_write || cmd.clr_write;
        mem_addr  = cmd.clr_write ? clr_cnt_reg : pix_addr;
        mem_wdata = cmd.clr_write ? 8'h00 : pix_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign result.pixel_value = value_reg;
    assign result.status      = status_reg;

endmodule

// ----- rtl/mfpe_ctrl.sv -----
// Controller state machine of the pixel engine: sequences request setup, memory
// read-modify-write, rectangle walk and clear sweeps. Depends on mfpe_pkg.
`timescale 1ns / 1ps

module mfpe_ctrl
    import mfpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     result_strobe
);

    typedef enum logic [6:0] {
        S_WIPE  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_READ  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_WIPE:
            begin
                cmd.clr_write = 1'b1;
                if (stat.last_clear)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (stat.op == OP_CLEAR)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end
                else if (!stat.range_ok)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.op == OP_FILL && stat.rect_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                if (stat.op == OP_GET)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.op == OP_FILL)
                begin
                    cmd.mem_write = 1'b1;
                    cmd.pix_step  = 1'b1;
                    state_next    = stat.last_pixel ? S_DONE : S_READ;
                end
                else
                begin
                    cmd.mem_write = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.last_clear)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = (state_reg == S_DONE);

endmodule

// ----- rtl/mono_framebuffer_pixel_engine.sv -----
// Monochrome 1bpp framebuffer pixel engine, two screens of 9600 bytes in one
// 32 KiB single-port byte memory. A request is taken when start is high and busy
// is low; exactly one result follows, valid for the single cycle in which
// result_strobe is high, and it must be taken then. The pace is set by the one
// read-modify-write memory port: a rejected or empty request does not touch the
// memory; fill rectangle makes one read and one write per pixel; clear both
// screens writes one byte per cycle. After reset the block runs a clearing pass
// with busy high; configuration writes are taken at any time but must only be
// made while the block is idle.
// Depends on mfpe_pkg, mfpe_ctrl, mfpe_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mono_framebuffer_pixel_engine
    import mfpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    input  request_t    request,
    output logic        busy,
    output result_t     result,
    output logic        result_strobe,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] screen_select_reg;
    logic       portrait_mode_reg;
    logic       cfg_write;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_select_reg <= 2'd1;
            portrait_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCREEN_SELECT: screen_select_reg <= pwdata[1:0];
                REG_PORTRAIT_MODE: portrait_mode_reg <= pwdata[0];
                default:           screen_select_reg <= screen_select_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_SCREEN_SELECT: prdata = {30'd0, screen_select_reg};
            REG_PORTRAIT_MODE: prdata = {31'd0, portrait_mode_reg};
            default:           prdata = '0;
        endcase
    end

    mfpe_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    mfpe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .screen_select (screen_select_reg),
        .portrait_mode (portrait_mode_reg),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result)
    );

    // Checks
    `ASSERT_NEXT(a_strobe_single, clk, rst_n, result_strobe, !result_strobe, "result strobe longer than one cycle")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted transfer did not raise busy")
    `ASSERT_SAME(a_strobe_busy, clk, rst_n, result_strobe, busy, "result strobe while idle")
    `ASSERT_SAME(a_reject_value, clk, rst_n, result_strobe && result.status, !result.pixel_value, "rejected request returned a pixel value")

endmodule
